// ===== sv/abts_pkg.sv =====
// Package: transaction types, function and status codes for the tree store.
package abts_pkg;

  localparam int unsigned DefCapacity = 15;

  localparam logic [2:0] FUNC_INSERT = 3'd0;
  localparam logic [2:0] FUNC_REMOVE = 3'd1;
  localparam logic [2:0] FUNC_LEFT   = 3'd2;
  localparam logic [2:0] FUNC_RIGHT  = 3'd3;
  localparam logic [2:0] FUNC_SIB    = 3'd4;
  localparam logic [2:0] FUNC_PARENT = 3'd5;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_FULL        = 3'd1;
  localparam logic [2:0] STAT_EMPTY       = 3'd2;
  localparam logic [2:0] STAT_NOT_FOUND   = 3'd3;
  localparam logic [2:0] STAT_NO_RELATIVE = 3'd4;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] relative;
    logic [3:0] node_count;
  } rsp_t;

endpackage

// ===== sv/abts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module abts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/array_binary_tree_store_top.sv =====
// Top level: level-order binary tree store with key scan and relative lookup.
//
//   channel   direction  handshake               payload
//   request   in         start, busy             req_i  (func, key)
//   result    out        done_o (one cycle)      rsp_o  (status, relative, node_count)
//
// Insert, remove, unknown codes and lookups on an empty tree: result in the cycle
// after acceptance, busy stays low. A lookup reads one slot per cycle from the
// registered-read node RAM, from slot 1 until the first match or the last filled
// slot, then on a match with a valid relative reads that slot too; busy high meanwhile.
// Reset clears the state, the node count and the result strobe; the RAM needs no clearing.
// The receiver cannot stall; each result is shown for exactly one cycle.
module array_binary_tree_store_top #(
  parameter int unsigned CAPACITY = abts_pkg::DefCapacity
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  abts_pkg::req_t req_i,
  output logic          done_o,
  output abts_pkg::rsp_t rsp_o
);
  import abts_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = CW + 1;
  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);
  localparam logic [CW-1:0] One = CW'(1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_REL  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] ptr_q, ptr_d;
  logic [2:0] func_q, func_d;
  logic [7:0] key_q, key_d;
  logic done_q, done_d;
  rsp_t rsp_q, rsp_d;

  logic we;
  logic [CW-1:0] waddr, raddr;
  logic [7:0] rdata;
  logic [PW-1:0] pos;
  logic pos_ok;
  logic [CW+3:0] cnt_ext;

  abts_ram #(
    .WIDTH(8),
    .DEPTH(CAPACITY + 1),
    .AW   (CW)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(req_i.key),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    case (func_q)
      FUNC_LEFT:  pos = {ptr_q, 1'b0};
      FUNC_RIGHT: pos = {ptr_q, 1'b1};
      FUNC_SIB: begin
        if (ptr_q == One) begin
          pos = '0;
        end else if (!ptr_q[0]) begin
          pos = {1'b0, ptr_q} + PW'(1);
        end else begin
          pos = {1'b0, ptr_q} - PW'(1);
        end
      end
      default:    pos = {1'b0, ptr_q} >> 1;
    endcase
    pos_ok = (pos != '0) && (pos <= {1'b0, count_q});
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ptr_d   = ptr_q;
    func_d  = func_q;
    key_d   = key_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    we      = 1'b0;
    waddr   = count_q + One;
    raddr   = One;
    rsp_d.status   = STAT_OK;
    rsp_d.relative = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          unique case (req_i.func)
            FUNC_INSERT: begin
              done_d = 1'b1;
              if (count_q == CapVal) begin
                rsp_d.status = STAT_FULL;
              end else begin
                we      = 1'b1;
                count_d = count_q + One;
              end
            end
            FUNC_REMOVE: begin
              done_d = 1'b1;
              if (count_q == '0) begin
                rsp_d.status = STAT_EMPTY;
              end else begin
                count_d = count_q - One;
              end
            end
            FUNC_LEFT, FUNC_RIGHT, FUNC_SIB, FUNC_PARENT: begin
              if (count_q == '0) begin
                done_d       = 1'b1;
                rsp_d.status = STAT_NOT_FOUND;
              end else begin
                state_d = ST_SCAN;
                ptr_d   = One;
                func_d  = req_i.func;
                key_d   = req_i.key;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (rdata == key_q) begin
          if (pos_ok) begin
            raddr   = pos[CW-1:0];
            state_d = ST_REL;
          end else begin
            done_d       = 1'b1;
            rsp_d.status = STAT_NO_RELATIVE;
            state_d      = ST_IDLE;
          end
        end else if (ptr_q == count_q) begin
          done_d       = 1'b1;
          rsp_d.status = STAT_NOT_FOUND;
          state_d      = ST_IDLE;
        end else begin
          ptr_d = ptr_q + One;
          raddr = ptr_q + One;
        end
      end
      ST_REL: begin
        done_d         = 1'b1;
        rsp_d.relative = rdata;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    cnt_ext          = {4'b0000, count_d};
    rsp_d.node_count = cnt_ext[3:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    func_q <= func_d;
    key_q  <= key_d;
    rsp_q  <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a lookup is in progress");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapVal)
    else $error("node count exceeds capacity");

  a_scan_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (ptr_q != '0) && (ptr_q <= count_q))
    else $error("scan pointer outside the filled slots");

  a_rel_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REL) |=> done_o && (rsp_o.status == STAT_OK))
    else $error("relative read did not produce an ok result");

endmodule

// ===== test/testbench.sv =====
// Testbench: directed and random command stream against the tree store, checked by a predictor or pinned results.
`timescale 1ns / 1ps

module testbench;
  import abts_pkg::*;

  localparam int unsigned CAPACITY = DefCapacity;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 625;
  localparam logic [2:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [2:0] FUNC_SPARE_7 = 3'd7;

  typedef struct {
    req_t req;
    bit   pinned;
    rsp_t rsp;
  } plan_entry_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  req_t req_i = '0;
  logic done_o;
  rsp_t rsp_o;

  bit   pin_valid = 1'b0;
  rsp_t pin_rsp = '0;

  logic [7:0]  shadow_keys [1:CAPACITY];
  int unsigned shadow_size = 0;
  rsp_t        pending_responses [$];
  logic [7:0]  sent_keys [$];
  plan_entry_t stimulus_plan [$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  array_binary_tree_store_top #(.CAPACITY(CAPACITY)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic rsp_t predict_tree_response(req_t r);
    rsp_t        o;
    int unsigned hit;
    int unsigned pos;
    int unsigned i;
    o = '0;
    hit = 0;
    pos = 0;
    case (r.func)
      FUNC_INSERT: begin
        if (shadow_size >= CAPACITY) begin
          o.status = STAT_FULL;
        end else begin
          shadow_size++;
          shadow_keys[shadow_size] = r.key;
        end
      end
      FUNC_REMOVE: begin
        if (shadow_size == 0) begin
          o.status = STAT_EMPTY;
        end else begin
          shadow_size--;
        end
      end
      FUNC_LEFT, FUNC_RIGHT, FUNC_SIB, FUNC_PARENT: begin
        for (i = 1; i <= shadow_size; i++) begin
          if (hit == 0 && shadow_keys[i] == r.key) hit = i;
        end
        if (hit == 0) begin
          o.status = STAT_NOT_FOUND;
        end else begin
          case (r.func)
            FUNC_LEFT:  pos = 2 * hit;
            FUNC_RIGHT: pos = 2 * hit + 1;
            FUNC_SIB:   pos = (hit == 1) ? 0 : ((hit[0] == 1'b0) ? hit + 1 : hit - 1);
            default:    pos = hit / 2;
          endcase
          if (pos == 0 || pos > shadow_size) begin
            o.status = STAT_NO_RELATIVE;
          end else begin
            o.relative = shadow_keys[pos];
          end
        end
      end
      default: ;
    endcase
    o.node_count = shadow_size[3:0];
    return o;
  endfunction

  task automatic note_mismatch(string what, rsp_t exp_rsp, rsp_t act_rsp);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch (%s): expected status %0d relative %02h count %0d, got status %0d relative %02h count %0d",
               what, exp_rsp.status, exp_rsp.relative, exp_rsp.node_count,
               act_rsp.status, act_rsp.relative, act_rsp.node_count);
    end
  endtask

  always @(posedge clk_i) begin : response_monitor
    rsp_t expected_rsp;
    rsp_t model_rsp;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_responses.size() == 0) begin
          note_mismatch("unexpected transaction", '0, rsp_o);
        end else begin
          expected_rsp = pending_responses.pop_front();
          if (rsp_o.status !== expected_rsp.status ||
              rsp_o.relative !== expected_rsp.relative ||
              rsp_o.node_count !== expected_rsp.node_count) begin
            note_mismatch("field", expected_rsp, rsp_o);
          end
        end
      end
      if (start && !busy) begin
        model_rsp = predict_tree_response(req_i);
        pending_responses.push_back(pin_valid ? pin_rsp : model_rsp);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("array_binary_tree_store_top regression: fail");
      $finish;
    end
  end

  task automatic plan_row(logic [2:0] func, logic [7:0] key, bit pinned,
                          logic [2:0] status, logic [7:0] relative, logic [3:0] count);
    plan_entry_t e;
    e.req.func = func;
    e.req.key = key;
    e.pinned = pinned;
    e.rsp.status = status;
    e.rsp.relative = relative;
    e.rsp.node_count = count;
    stimulus_plan.push_back(e);
  endtask

  task automatic issue(req_t r, bit pinned, rsp_t pinned_rsp, bit no_idle);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    pin_valid <= pinned;
    pin_rsp <= pinned_rsp;
    if (r.func == FUNC_INSERT) begin
      sent_keys.push_back(r.key);
      if (sent_keys.size() > 16) void'(sent_keys.pop_front());
    end
    do @(posedge clk_i); while (busy);
  endtask

  function automatic req_t random_request(bit grow);
    req_t        r;
    int unsigned roll;
    int unsigned insert_pct;
    insert_pct = grow ? 40 : 15;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) begin
      r.func = FUNC_INSERT;
    end else if (roll < 50) begin
      r.func = FUNC_REMOVE;
    end else if (roll < 95) begin
      r.func = FUNC_LEFT + 3'($urandom_range(0, 3));
    end else begin
      r.func = $urandom_range(0, 1) ? FUNC_SPARE_7 : FUNC_SPARE_6;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60 && sent_keys.size() > 0) begin
      r.key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    end else if (roll < 80) begin
      r.key = 8'($urandom_range(0, 7));
    end else begin
      r.key = 8'($urandom_range(0, 255));
    end
    return r;
  endfunction

  initial begin : stimulus
    int unsigned k;
    bit          grow;
    plan_row(FUNC_REMOVE, 8'h00, 1'b1, STAT_EMPTY, 8'h00, 4'd0);
    plan_row(FUNC_PARENT, 8'h00, 1'b1, STAT_NOT_FOUND, 8'h00, 4'd0);
    plan_row(FUNC_SPARE_7, 8'hFF, 1'b1, STAT_OK, 8'h00, 4'd0);
    plan_row(FUNC_INSERT, 8'h00, 1'b1, STAT_OK, 8'h00, 4'd1);
    plan_row(FUNC_INSERT, 8'hFF, 1'b1, STAT_OK, 8'h00, 4'd2);
    plan_row(FUNC_PARENT, 8'h00, 1'b1, STAT_NO_RELATIVE, 8'h00, 4'd2);
    plan_row(FUNC_SIB, 8'h00, 1'b1, STAT_NO_RELATIVE, 8'h00, 4'd2);
    plan_row(FUNC_LEFT, 8'h00, 1'b1, STAT_OK, 8'hFF, 4'd2);
    plan_row(FUNC_RIGHT, 8'h00, 1'b1, STAT_NO_RELATIVE, 8'h00, 4'd2);
    plan_row(FUNC_SIB, 8'hFF, 1'b1, STAT_NO_RELATIVE, 8'h00, 4'd2);
    plan_row(FUNC_PARENT, 8'hFF, 1'b1, STAT_OK, 8'h00, 4'd2);
    plan_row(FUNC_SPARE_6, 8'h00, 1'b1, STAT_OK, 8'h00, 4'd2);
    for (k = 0; k < 13; k++) begin
      plan_row(FUNC_INSERT, 8'h10 + 8'(k), 1'b0, STAT_OK, 8'h00, 4'd0);
    end
    plan_row(FUNC_RIGHT, 8'h1C, 1'b1, STAT_NO_RELATIVE, 8'h00, 4'd15);
    plan_row(FUNC_INSERT, 8'hAA, 1'b1, STAT_FULL, 8'h00, 4'd15);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stimulus_plan[i]) begin
      issue(stimulus_plan[i].req, stimulus_plan[i].pinned, stimulus_plan[i].rsp, 1'b0);
    end

    grow = 1'b1;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 40 == 0) grow = ~grow;
      if (k == RANDOM_ITEMS / 2) begin
        // hold off until every pending transaction has drained
        start <= 1'b0;
        while (pending_responses.size() != 0) @(posedge clk_i);
      end
      issue(random_request(grow), 1'b0, '0, (k % 64) < 16);
    end

    start <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (CAPACITY + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("array_binary_tree_store_top regression: pass");
    end else begin
      $display("array_binary_tree_store_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/abts_pkg.sv
sv/abts_ram.sv
sv/array_binary_tree_store_top.sv
test/testbench.sv
